### design/chc_pkg.sv
// Shared types and constant tables for the cladding heat capacity interpolator.
// Holds the breakpoint and heat capacity tables and per-segment divider constants.
// No dependencies.
`default_nettype none

package chc_pkg;

  localparam int STORED_POINTS = 15;

  // Offset added to the interpolation numerator so that it stays non-negative.
  // The steepest falling segment moves the value by up to 9664 units of 1/64,
  // so the bias must exceed that.
  localparam int Q_BIAS  = 16384;
  localparam int OFS_MUL = 2 * Q_BIAS + 1;
  // Scale of the reciprocal constants.
  localparam int RECIP_SHIFT = 25;
  localparam longint RECIP_ONE = 64'd1 << RECIP_SHIFT;

  // Breakpoints in 1/16 K.
  localparam logic [15:0] BP_Q4 [STORED_POINTS] = '{
    16'(300 * 16),  16'(400 * 16),  16'(640 * 16),  16'(1090 * 16), 16'(1093 * 16),
    16'(1113 * 16), 16'(1133 * 16), 16'(1153 * 16), 16'(1173 * 16), 16'(1193 * 16),
    16'(1213 * 16), 16'(1233 * 16), 16'(1248 * 16), 16'(2098 * 16), 16'(2099 * 16)
  };

  // Heat capacity values in 1/64 J/kg-K.
  localparam logic [15:0] CP_Q6 [STORED_POINTS] = '{
    16'(281 * 64), 16'(302 * 64), 16'(331 * 64), 16'(375 * 64), 16'(502 * 64),
    16'(590 * 64), 16'(615 * 64), 16'(719 * 64), 16'(816 * 64), 16'(770 * 64),
    16'(619 * 64), 16'(469 * 64), 16'(356 * 64), 16'(356 * 64), 16'(356 * 64)
  };

  localparam logic [15:0] CP_MIN_Q6 = 16'(281 * 64);
  localparam logic [15:0] CP_MAX_Q6 = 16'(816 * 64);

  // Per-segment step of the table value in whole J/kg-K. The final entry
  // belongs to no segment and is never used for interpolation.
  localparam logic signed [8:0] SEG_DK [STORED_POINTS] = '{
    9'sd21, 9'sd29, 9'sd44, 9'sd127, 9'sd88, 9'sd25, 9'sd104, 9'sd97,
    -9'sd46, -9'sd151, -9'sd150, -9'sd113, 9'sd0, 9'sd0, 9'sd0
  };

  // Twice the segment width in whole kelvin: the divisor.
  localparam logic [10:0] SEG_DEN [STORED_POINTS] = '{
    11'd200, 11'd480, 11'd900, 11'd6, 11'd40, 11'd40, 11'd40, 11'd40,
    11'd40, 11'd40, 11'd40, 11'd30, 11'd1700, 11'd2, 11'd2
  };

  // Numerator offset: half the divisor for rounding plus the bias term.
  localparam logic [24:0] SEG_OFF [STORED_POINTS] = '{
    25'(OFS_MUL * 100), 25'(OFS_MUL * 240), 25'(OFS_MUL * 450), 25'(OFS_MUL * 3),
    25'(OFS_MUL * 20),  25'(OFS_MUL * 20),  25'(OFS_MUL * 20),  25'(OFS_MUL * 20),
    25'(OFS_MUL * 20),  25'(OFS_MUL * 20),  25'(OFS_MUL * 20),  25'(OFS_MUL * 15),
    25'(OFS_MUL * 850), 25'(OFS_MUL * 1),   25'(OFS_MUL * 1)
  };

  // Reciprocal of the divisor, floor(2^25 / divisor).
  localparam logic [24:0] SEG_RECIP [STORED_POINTS] = '{
    25'(RECIP_ONE / 200), 25'(RECIP_ONE / 480), 25'(RECIP_ONE / 900),
    25'(RECIP_ONE / 6),   25'(RECIP_ONE / 40),  25'(RECIP_ONE / 40),
    25'(RECIP_ONE / 40),  25'(RECIP_ONE / 40),  25'(RECIP_ONE / 40),
    25'(RECIP_ONE / 40),  25'(RECIP_ONE / 40),  25'(RECIP_ONE / 30),
    25'(RECIP_ONE / 1700), 25'(RECIP_ONE / 2),  25'(RECIP_ONE / 2)
  };

  // Result of the segment search stage.
  typedef struct packed {
    logic        valid;
    logic        oor;
    logic        last;
    logic [3:0]  seg;
    logic [13:0] delta;
  } loc_t;

  // Operands handed to the divider stages.
  typedef struct packed {
    logic        valid;
    logic        bypass;
    logic        oor;
    logic [15:0] fixed_value;
    logic [15:0] base;
    logic [24:0] num;
    logic [10:0] den;
    logic [24:0] recip;
  } div_in_t;

endpackage

`default_nettype wire

### design/clad_heat_capacity_interp.sv
// Top level of the cladding heat capacity interpolator.
// Depends on chc_pkg, chc_locate and chc_recip_div.
`default_nettype none

// Usage.
// A temperature (unsigned, 4 fraction bits, kelvin) is offered on temperature
// with start high; the transfer takes place at the rising edge where start is
// high and busy is low. busy is always low, so a new temperature may be
// offered in every cycle and the block sustains one transfer per clock.
// Each transfer produces exactly one result: done is high for one cycle with
// heat_capacity (unsigned, 6 fraction bits, J/kg-K, rounded to nearest) and
// off_table, and results leave in the order the temperatures arrived.
// Temperatures below the first or above the last breakpoint give
// off_table high and a heat capacity of zero.
// The work runs through four register stages: segment search, numerator
// formation with a narrow multiplier, a reciprocal multiply, and a correction
// with the final sum.
// The receiver has no way to hold results off; a result is taken in the cycle
// in which done is high. Synchronous reset clears the valid bits of every
// stage, so items in flight are dropped and no stale result emerges.
module clad_heat_capacity_interp #(
  parameter int TABLE_POINTS = 15
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [15:0] temperature,
  output logic             done,
  output logic [15:0]      heat_capacity,
  output logic             off_table
);
  import chc_pkg::*;

  localparam int USED = (TABLE_POINTS > STORED_POINTS) ? STORED_POINTS :
                        ((TABLE_POINTS < 2) ? 2 : TABLE_POINTS);
  localparam int LAST = USED - 1;

  loc_t    loc;
  div_in_t dreg;

  logic signed [23:0] step_prod;
  logic signed [26:0] num_s;

  // The pipeline never stalls, so a transfer is possible in every cycle.
  assign busy = 1'b0;

  // Stage one: find the segment.
  chc_locate #(
    .TABLE_POINTS (TABLE_POINTS)
  ) u_locate (
    .clk         (clk),
    .rst         (rst),
    .start       (start),
    .temperature (temperature),
    .loc         (loc)
  );

  // Stage two: form the numerator 8*dk*d + (2*bias + 1)*S, which is the
  // rounding numerator shifted by a bias so that it never goes negative.
  always_comb begin
    step_prod = SEG_DK[loc.seg] * $signed({1'b0, loc.delta});
    num_s     = $signed({step_prod, 3'b000}) + $signed({2'd0, SEG_OFF[loc.seg]});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dreg.valid <= 1'b0;
    end else begin
      dreg.valid <= loc.valid;
    end
    dreg.bypass      <= loc.oor || loc.last;
    dreg.oor         <= loc.oor;
    dreg.fixed_value <= loc.oor ? 16'd0 : CP_Q6[LAST];
    dreg.base        <= CP_Q6[loc.seg] - 16'(Q_BIAS);
    dreg.num         <= num_s[24:0];
    dreg.den         <= SEG_DEN[loc.seg];
    dreg.recip       <= SEG_RECIP[loc.seg];
  end

  // Stages three and four: divide, correct, and add the segment base.
  chc_recip_div u_div (
    .clk           (clk),
    .rst           (rst),
    .din           (dreg),
    .done          (done),
    .heat_capacity (heat_capacity),
    .off_table     (off_table)
  );

  // Every accepted temperature gives one result strobe, and no strobe comes without one.
  a_latency: assert property (@(posedge clk) disable iff (rst)
    (!$past(rst, 1) && !$past(rst, 2) && !$past(rst, 3) && !$past(rst, 4))
      |-> (done == $past(start, 4)))
    else $error("result strobe does not follow the accepted transfer");

  // A temperature outside the table must give zero.
  a_oor_zero: assert property (@(posedge clk) disable iff (rst)
    (done && off_table) |-> (heat_capacity == 16'd0))
    else $error("off-table result is not zero");

  // An interpolated value lies within the span of the table values.
  a_in_span: assert property (@(posedge clk) disable iff (rst)
    (done && !off_table) |-> ((heat_capacity >= CP_MIN_Q6) && (heat_capacity <= CP_MAX_Q6)))
    else $error("interpolated value outside the table span");

endmodule

`default_nettype wire

### design/chc_locate.sv
// Segment search stage: finds the breakpoint segment that holds the temperature.
// Depends on chc_pkg for the breakpoint table and the loc_t type.
`default_nettype none

module chc_locate #(
  parameter int TABLE_POINTS = 15
) (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         start,
  input  wire logic [15:0]  temperature,
  output chc_pkg::loc_t     loc
);
  import chc_pkg::*;

  localparam int USED = (TABLE_POINTS > STORED_POINTS) ? STORED_POINTS :
                        ((TABLE_POINTS < 2) ? 2 : TABLE_POINTS);
  localparam int LAST = USED - 1;
  localparam logic [3:0] LAST_SEG = 4'(LAST);

  logic [3:0]  seg_next;
  logic        oor_next;
  logic [15:0] diff;

  // The breakpoints rise, so the last one not above the temperature wins.
  always_comb begin
    seg_next = '0;
    for (int k = 1; k < STORED_POINTS; k++) begin
      if ((k < USED) && (temperature >= BP_Q4[k])) begin
        seg_next = 4'(k);
      end
    end
    oor_next = (temperature < BP_Q4[0]) || (temperature > BP_Q4[LAST]);
    diff     = temperature - BP_Q4[seg_next];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      loc.valid <= 1'b0;
    end else begin
      loc.valid <= start;
    end
    loc.oor   <= oor_next;
    loc.last  <= (seg_next == LAST_SEG);
    loc.seg   <= seg_next;
    loc.delta <= diff[13:0];
  end

endmodule

`default_nettype wire

### design/chc_recip_div.sv
// Two-stage rounding divider by reciprocal multiplication with one correction step.
// Depends on chc_pkg for the div_in_t type and scaling constants.
`default_nettype none

module chc_recip_div (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire chc_pkg::div_in_t din,
  output logic                  done,
  output logic [15:0]           heat_capacity,
  output logic                  off_table
);
  import chc_pkg::*;

  logic [49:0] prod;
  logic        a_valid;
  logic        a_bypass;
  logic        a_oor;
  logic [15:0] a_fixed;
  logic [15:0] a_base;
  logic [24:0] a_num;
  logic [10:0] a_den;
  logic [14:0] a_quot;

  logic [25:0] back;
  logic [24:0] rem;
  logic        corr;
  logic [15:0] value;

  // The estimate is at most one below the true quotient.
  assign prod = 50'(din.num) * 50'(din.recip);

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else begin
      a_valid <= din.valid;
    end
  end

  always_ff @(posedge clk) begin
    a_bypass <= din.bypass;
    a_oor    <= din.oor;
    a_fixed  <= din.fixed_value;
    a_base   <= din.base;
    a_num    <= din.num;
    a_den    <= din.den;
    a_quot   <= prod[RECIP_SHIFT + 14:RECIP_SHIFT];
  end

  always_comb begin
    back  = 26'(a_quot) * 26'(a_den);
    rem   = a_num - 25'(back);
    corr  = (rem >= 25'(a_den));
    value = a_bypass ? a_fixed : (a_base + 16'(a_quot) + 16'(corr));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= a_valid;
    end
  end

  always_ff @(posedge clk) begin
    heat_capacity <= value;
    off_table     <= a_oor;
  end

endmodule

`default_nettype wire
